@@ hdl/gsr_pkg.sv @@
// Shared types and constants for the game-pad serial responder.
// Used by gsr_engine, gamepad_serial_responder and the testbench files; depends on nothing.
`default_nettype none

package gsr_pkg;

  // Frame and rumble map sizes
  localparam int FrameBytes  = 9;
  localparam int RumbleSlots = 6;

  // Item kinds
  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_READ     = 3'd1;
  localparam logic [2:0] KIND_PRESS    = 3'd2;
  localparam logic [2:0] KIND_RELEASE  = 3'd3;
  localparam logic [2:0] KIND_AXIS     = 3'd4;
  localparam logic [2:0] KIND_MODE_BTN = 3'd5;

  // Host commands
  localparam logic [7:0] CMD_NONE       = 8'h00;
  localparam logic [7:0] CMD_POLL       = 8'h42;
  localparam logic [7:0] CMD_CONFIG     = 8'h43;
  localparam logic [7:0] CMD_SET_MODE   = 8'h44;
  localparam logic [7:0] CMD_STATUS     = 8'h45;
  localparam logic [7:0] CMD_CONST_46   = 8'h46;
  localparam logic [7:0] CMD_CONST_47   = 8'h47;
  localparam logic [7:0] CMD_CONST_48   = 8'h48;
  localparam logic [7:0] CMD_CONST_4C   = 8'h4c;
  localparam logic [7:0] CMD_RUMBLE_MAP = 8'h4d;
  localparam logic [3:0] CMD_GROUP      = 4'h4;

  // Reply bytes
  localparam logic [7:0] BYTE_IDLE  = 8'hff;
  localparam logic [7:0] STATUS_OK  = 8'h5a;
  localparam logic [7:0] ID_CONFIG  = 8'hf3;
  localparam logic [7:0] ID_ANALOG  = 8'h70;
  localparam logic [7:0] ID_DIGITAL = 8'h40;
  localparam logic [7:0] SLOT_FREE  = 8'hff;
  localparam logic [7:0] STICK_MID  = 8'h80;
  localparam logic [7:0] STICK_LOW  = 8'd64;
  localparam logic [7:0] STICK_HIGH = 8'd192;

  // Transfer phases
  localparam logic [3:0] PH_HIZ   = 4'd0;
  localparam logic [3:0] PH_IDLE  = 4'd1;
  localparam logic [3:0] PH_PARAM = 4'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  host_byte;
    logic [15:0] button_mask;
    logic [1:0]  axis_select;
    logic [7:0]  axis_value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       tx_ready;
    logic [7:0] small_motor;
    logic [7:0] large_motor;
    logic       analog_mode;
  } result_t;

  typedef struct packed {
    logic [3:0]                        phase;
    logic [7:0]                        cmd;
    logic [7:0]                        param;
    logic [3:0]                        frame_len;
    logic [FrameBytes-1:0][7:0]        frame;
    logic [RumbleSlots-1:0][7:0]       slots;
    logic [1:0][7:0]                   motor;
    logic [15:0]                       buttons;
    logic [3:0][7:0]                   sticks;
    logic                              analog;
    logic                              config_on;
    logic                              dualshock;
    logic                              lock;
    logic                              status_ok;
    logic                              ready;
  } pad_state_t;

endpackage

`default_nettype wire

@@ hdl/gsr_engine.sv @@
// Pad state registers and the single-pass update for one transfer.
// Depends on gsr_pkg.
`default_nettype none

module gsr_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire gsr_pkg::item_t   item,
  output gsr_pkg::result_t      result
);
  import gsr_pkg::*;

  pad_state_t st;
  pad_state_t st_next;
  logic [7:0] rb;
  logic [3:0] pos;
  logic [2:0] slot;
  logic [7:0] slot_val;
  logic       cmd_ok;
  logic       used0;
  logic       used1;

  // Abandon the current transfer
  function automatic pad_state_t drop_xfer(pad_state_t s);
    pad_state_t r;
    r           = s;
    r.phase     = PH_HIZ;
    r.ready     = 1'b0;
    r.cmd       = CMD_NONE;
    r.param     = 8'd0;
    r.frame_len = 4'd0;
    r.frame     = '0;
    return r;
  endfunction

  function automatic pad_state_t clear_rumble(pad_state_t s);
    pad_state_t r;
    r = s;
    for (int i = 0; i < RumbleSlots; i++) r.slots[i] = SLOT_FREE;
    r.motor = '0;
    return r;
  endfunction

  // Buttons with the left stick folded into the d-pad in digital mode
  function automatic logic [15:0] pad_buttons(pad_state_t s);
    logic [15:0] b;
    b = s.buttons;
    if (!s.analog && !s.config_on) begin
      if (s.sticks[2] <= STICK_LOW)  b[7] = 1'b0;
      if (s.sticks[2] >= STICK_HIGH) b[5] = 1'b0;
      if (s.sticks[3] <= STICK_LOW)  b[4] = 1'b0;
      if (s.sticks[3] >= STICK_HIGH) b[6] = 1'b0;
    end
    return b;
  endfunction

  function automatic pad_state_t build_frame(pad_state_t s, logic [7:0] cmd);
    pad_state_t  r;
    logic        wide;
    logic [1:0]  half;
    logic [15:0] b;
    r    = s;
    wide = s.analog || s.config_on;
    half = wide ? 2'd3 : 2'd1;
    if (!wide && s.dualshock) begin
      if (s.slots[4] != SLOT_FREE || s.slots[5] != SLOT_FREE)      half = 2'd3;
      else if (s.slots[2] != SLOT_FREE || s.slots[3] != SLOT_FREE) half = 2'd2;
    end
    b           = pad_buttons(s);
    r.frame     = '0;
    r.cmd       = cmd;
    r.param     = 8'd0;
    r.frame_len = 4'd3 + {1'b0, half, 1'b0};
    r.frame[0]  = BYTE_IDLE;
    r.frame[1]  = s.config_on ? ID_CONFIG
                              : ((s.analog ? ID_ANALOG : ID_DIGITAL) | {6'd0, half});
    r.frame[2]  = s.status_ok ? STATUS_OK : 8'h00;
    if (cmd == CMD_POLL || (cmd == CMD_CONFIG && !s.config_on)) begin
      r.frame[3] = b[7:0];
      r.frame[4] = b[15:8];
      if (wide) begin
        r.frame[5] = s.sticks[0];
        r.frame[6] = s.sticks[1];
        r.frame[7] = s.sticks[2];
        r.frame[8] = s.sticks[3];
      end
    end else if (cmd == CMD_STATUS) begin
      r.frame[3] = 8'd1;
      r.frame[4] = 8'd2;
      r.frame[5] = {7'd0, s.analog};
      r.frame[6] = 8'd2;
      r.frame[7] = 8'd1;
    end
    return r;
  endfunction

  function automatic pad_state_t reset_state();
    pad_state_t r;
    r           = '0;
    r.ready     = 1'b1;
    r.buttons   = 16'hffff;
    for (int i = 0; i < 4; i++) r.sticks[i] = STICK_MID;
    r.status_ok = 1'b1;
    r           = clear_rumble(r);
    return r;
  endfunction

  // Decode parameter position and rumble slot lookups
  assign pos      = st.phase - PH_PARAM;
  assign slot     = pos[2:0];
  assign slot_val = st.slots[slot];
  assign cmd_ok   = (item.host_byte == CMD_POLL) || (item.host_byte == CMD_CONFIG) ||
                    (st.config_on && item.host_byte[7:4] == CMD_GROUP);

  always_comb begin
    used0 = 1'b0;
    used1 = 1'b0;
    for (int i = 0; i < RumbleSlots - 1; i++) begin
      if (st.slots[i] == 8'd0) used0 = 1'b1;
      if (st.slots[i] == 8'd1) used1 = 1'b1;
    end
    if (item.host_byte == 8'd0) used0 = 1'b1;
    if (item.host_byte == 8'd1) used1 = 1'b1;
  end

  // Next state and read data for the item in the input register
  always_comb begin
    st_next = st;
    rb      = BYTE_IDLE;
    case (item.kind)
      KIND_WRITE: begin
        if (st.phase == PH_IDLE) begin
          if (cmd_ok) begin
            st_next       = build_frame(st, item.host_byte);
            st_next.ready = 1'b1;
            if (item.host_byte == CMD_SET_MODE) st_next = clear_rumble(st_next);
          end else begin
            st_next = drop_xfer(st);
          end
        end else if (st.phase >= PH_PARAM && st.cmd != CMD_NONE &&
                     pos < 4'(RumbleSlots)) begin
          if (pos == 4'd0) st_next.param = item.host_byte;
          case (st.cmd)
            CMD_POLL: begin
              if (st.dualshock) begin
                if (slot_val == 8'd0)
                  st_next.motor[0] = item.host_byte[0] ? 8'hff : 8'h00;
                else if (slot_val == 8'd1)
                  st_next.motor[1] = item.host_byte;
              end else if (pos == 4'd1) begin
                st_next.motor[0] = (st.param[7:6] == 2'b01 && item.host_byte[0])
                                   ? 8'hff : 8'h00;
              end
            end
            CMD_SET_MODE: begin
              if (pos == 4'd0 && item.host_byte <= 8'd1)
                st_next.analog = item.host_byte[0];
              else if (pos == 4'd1)
                st_next.lock = (item.host_byte[1:0] == 2'b11);
            end
            CMD_CONST_46: begin
              if (pos == 4'd0 && item.host_byte <= 8'd1) begin
                st_next.frame[5] = 8'd1;
                st_next.frame[6] = item.host_byte[0] ? 8'd1 : 8'd2;
                st_next.frame[7] = item.host_byte;
                st_next.frame[8] = item.host_byte[0] ? 8'h14 : 8'h0a;
              end
            end
            CMD_CONST_47: begin
              if (pos == 4'd0 && item.host_byte == 8'd0) begin
                st_next.frame[5] = 8'd2;
                st_next.frame[7] = 8'd1;
              end
            end
            CMD_CONST_48: begin
              if (pos == 4'd0 && item.host_byte <= 8'd1) st_next.frame[7] = 8'd1;
            end
            CMD_CONST_4C: begin
              if (pos == 4'd0 && item.host_byte <= 8'd1)
                st_next.frame[6] = item.host_byte[0] ? 8'd7 : 8'd4;
            end
            CMD_RUMBLE_MAP: begin
              st_next.frame[st.phase] = slot_val;
              st_next.slots[slot]     = item.host_byte;
              // On the last slot, stop motors no slot drives any more
              if (pos == 4'(RumbleSlots - 1)) begin
                if (!used0) st_next.motor[0] = 8'd0;
                if (!used1) st_next.motor[1] = 8'd0;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_READ: begin
        if (st.phase == PH_HIZ) begin
          st_next       = drop_xfer(st);
          st_next.phase = PH_IDLE;
          st_next.ready = 1'b1;
        end else if (st.cmd == CMD_NONE || st.phase >= st.frame_len ||
                     st.phase >= 4'(FrameBytes)) begin
          st_next = drop_xfer(st);
        end else begin
          rb            = st.frame[st.phase];
          st_next.phase = st.phase + 4'd1;
          // End of frame: a config command settles config mode; then drop the transfer
          if (st_next.phase == st.frame_len) begin
            if (st.cmd == CMD_CONFIG) begin
              st_next.config_on = (st.param == 8'd1);
              if (st.param == 8'd1) begin
                st_next.dualshock = 1'b1;
                st_next.status_ok = 1'b1;
              end
            end
            st_next = drop_xfer(st_next);
          end
        end
      end
      KIND_PRESS:   st_next.buttons = st.buttons & ~item.button_mask;
      KIND_RELEASE: st_next.buttons = st.buttons | item.button_mask;
      KIND_AXIS:    st_next.sticks[item.axis_select] = item.axis_value;
      KIND_MODE_BTN: begin
        if (!st.lock && !st.config_on) begin
          st_next        = clear_rumble(st);
          st_next.analog = !st.analog;
          if (st.dualshock) st_next.status_ok = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Hold state; advance on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
    end else if (fire) begin
      st <= st_next;
    end
  end

  assign result.read_byte   = rb;
  assign result.tx_ready    = st_next.ready;
  assign result.small_motor = st_next.motor[0];
  assign result.large_motor = st_next.motor[1];
  assign result.analog_mode = st_next.analog;

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    st.frame_len == 4'd0 || st.frame_len == 4'd5 || st.frame_len == 4'd7 ||
    st.frame_len == 4'd9)
    else $error("frame length out of set");

  a_cmd_len: assert property (@(posedge clk) disable iff (rst)
    (st.cmd == CMD_NONE) == (st.frame_len == 4'd0))
    else $error("command and frame length disagree");

  a_small_motor: assert property (@(posedge clk) disable iff (rst)
    st.motor[0] == 8'h00 || st.motor[0] == 8'hff)
    else $error("small motor not on/off");

  a_wake: assert property (@(posedge clk) disable iff (rst)
    (fire && item.kind == KIND_READ && st.phase == PH_HIZ)
    |=> (st.phase == PH_IDLE && st.ready))
    else $error("read in high impedance did not wake");

endmodule

`default_nettype wire

@@ hdl/gamepad_serial_responder.sv @@
// Path: input register, then result register, from input transfer to result valid.
// Throughput: one item per cycle if out_stall is low; an item enters while a result waits.
// Each item updates the pad state in the cycle it leaves the input register.
// Reset (rst, synchronous): empties both registers, pad state to power-on values.
// Top level of the game-pad serial responder; depends on gsr_pkg and gsr_engine.
`default_nettype none

module gamepad_serial_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  host_byte,
  input  wire logic [15:0] button_mask,
  input  wire logic [1:0]  axis_select,
  input  wire logic [7:0]  axis_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic             tx_ready,
  output logic [7:0]       small_motor,
  output logic [7:0]       large_motor,
  output logic             analog_mode
);
  import gsr_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t res;

  // Move the held item on when the result register is free or being emptied
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.kind        <= kind;
      s1_item.host_byte   <= host_byte;
      s1_item.button_mask <= button_mask;
      s1_item.axis_select <= axis_select;
      s1_item.axis_value  <= axis_value;
    end
  end

  gsr_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_byte   <= res.read_byte;
      tx_ready    <= res.tx_ready;
      small_motor <= res.small_motor;
      large_motor <= res.large_motor;
      analog_mode <= res.analog_mode;
    end
  end

endmodule

`default_nettype wire

@@ sim/pad_check_pkg.sv @@
// Scoreboard for the game-pad serial responder testbench: a mirror of the pad
// state that predicts each reply, and the queue of replies still owed.
// Depends on gsr_pkg for item and result types and the protocol codes.
`timescale 1ns / 1ps

package pad_check_pkg;
  import gsr_pkg::*;

  // Kinds the block does not decode
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // Last byte of the 0x46 constant reply
  localparam logic [7:0] CONST_46_SLOW = 8'h0a;
  localparam logic [7:0] CONST_46_FAST = 8'h14;

  class pad_scoreboard;
    // mirrored pad state
    logic [3:0]  phase;
    logic [7:0]  cmd;
    logic [7:0]  param;
    logic [3:0]  flen;
    logic [7:0]  frame [FrameBytes];
    logic [7:0]  slots [RumbleSlots];
    logic [7:0]  motor [2];
    logic [15:0] buttons;
    logic [7:0]  sticks [4];
    bit          analog, cfg, dshock, lock, stat_ok, ready;

    result_t     owed_replies[$];
    int unsigned errors, items, checked, frames, cfg_entries;

    function new();
      drop_link();
      ready = 1'b1;
      quiet_rumble();
      buttons = 16'hffff;
      foreach (sticks[i]) sticks[i] = STICK_MID;
      analog  = 1'b0;
      cfg     = 1'b0;
      dshock  = 1'b0;
      lock    = 1'b0;
      stat_ok = 1'b1;
      errors = 0;
      items = 0;
      checked = 0;
      frames = 0;
      cfg_entries = 0;
    endfunction

    // Close the transfer and forget the frame
    function void drop_link();
      phase = PH_HIZ;
      ready = 1'b0;
      cmd   = CMD_NONE;
      param = 8'h00;
      flen  = 4'd0;
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    function void quiet_rumble();
      foreach (slots[i]) slots[i] = SLOT_FREE;
      motor[0] = 8'h00;
      motor[1] = 8'h00;
    endfunction

    // Advance the mirror by one item and return the reply it causes
    function result_t pad_reply(item_t it);
      result_t     r;
      logic [15:0] b;
      logic [7:0]  d;
      logic [7:0]  m;
      int unsigned half;
      int          idx;
      bit          wide, hit0, hit1;
      d = it.host_byte;
      r.read_byte = BYTE_IDLE;
      case (it.kind)
        KIND_WRITE: begin
          if (phase == PH_IDLE) begin
            if (d != CMD_POLL && d != CMD_CONFIG && !(cfg && d[7:4] == CMD_GROUP)) begin
              drop_link();
            end else begin
              // build the reply frame for the new command
              wide = analog || cfg;
              half = wide ? 3 : 1;
              if (!wide && dshock)
                for (int i = 2; i < RumbleSlots; i++)
                  if (slots[i] != SLOT_FREE) half = 1 + i / 2;
              foreach (frame[i]) frame[i] = 8'h00;
              cmd   = d;
              param = 8'h00;
              flen  = 4'(3 + half * 2);
              frame[0] = BYTE_IDLE;
              frame[1] = cfg ? ID_CONFIG : ((analog ? ID_ANALOG : ID_DIGITAL) | 8'(half));
              frame[2] = stat_ok ? STATUS_OK : 8'h00;
              if (cmd == CMD_POLL || (cmd == CMD_CONFIG && !cfg)) begin
                b = buttons;
                // fold the left stick into the d-pad in digital mode
                if (!wide) begin
                  if (sticks[2] <= STICK_LOW)  b[7] = 1'b0;
                  if (sticks[2] >= STICK_HIGH) b[5] = 1'b0;
                  if (sticks[3] <= STICK_LOW)  b[4] = 1'b0;
                  if (sticks[3] >= STICK_HIGH) b[6] = 1'b0;
                end
                frame[3] = b[7:0];
                frame[4] = b[15:8];
                if (wide)
                  for (int i = 0; i < 4; i++) frame[5 + i] = sticks[i];
              end else if (cmd == CMD_STATUS) begin
                frame[3] = 8'd1;
                frame[4] = 8'd2;
                frame[5] = analog ? 8'd1 : 8'd0;
                frame[6] = 8'd2;
                frame[7] = 8'd1;
              end
              ready = 1'b1;
              if (cmd == CMD_SET_MODE) quiet_rumble();
            end
          end else if (phase >= PH_PARAM && cmd != CMD_NONE &&
                       int'(phase) - int'(PH_PARAM) < RumbleSlots) begin
            idx = int'(phase) - int'(PH_PARAM);
            if (idx == 0) param = d;
            case (cmd)
              CMD_POLL: begin
                if (dshock) begin
                  m = slots[idx];
                  if (m == 8'd0) motor[0] = {8{d[0]}};
                  else if (m == 8'd1) motor[1] = d;
                end else if (idx == 1) begin
                  motor[0] = (param[7:6] == 2'b01 && d[0]) ? 8'hff : 8'h00;
                end
              end
              CMD_SET_MODE: begin
                if (idx == 0 && d <= 8'd1) analog = (d == 8'd1);
                else if (idx == 1) lock = (d[1:0] == 2'b11);
              end
              CMD_CONST_46: begin
                if (idx == 0 && d <= 8'd1) begin
                  frame[5] = 8'd1;
                  frame[6] = d[0] ? 8'd1 : 8'd2;
                  frame[7] = d;
                  frame[8] = d[0] ? CONST_46_FAST : CONST_46_SLOW;
                end
              end
              CMD_CONST_47: begin
                if (idx == 0 && d == 8'd0) begin
                  frame[5] = 8'd2;
                  frame[7] = 8'd1;
                end
              end
              CMD_CONST_48: begin
                if (idx == 0 && d <= 8'd1) frame[7] = 8'd1;
              end
              CMD_CONST_4C: begin
                if (idx == 0 && d <= 8'd1) frame[6] = d[0] ? 8'd7 : 8'd4;
              end
              CMD_RUMBLE_MAP: begin
                // echo the old slot, store the new one
                if (phase < FrameBytes) frame[phase] = slots[idx];
                slots[idx] = d;
                if (idx == RumbleSlots - 1) begin
                  hit0 = 1'b0;
                  hit1 = 1'b0;
                  foreach (slots[i]) begin
                    if (slots[i] == 8'd0) hit0 = 1'b1;
                    if (slots[i] == 8'd1) hit1 = 1'b1;
                  end
                  if (!hit0) motor[0] = 8'h00;
                  if (!hit1) motor[1] = 8'h00;
                end
              end
              default: ;
            endcase
          end
        end
        KIND_READ: begin
          if (phase == PH_HIZ) begin
            drop_link();
            phase = PH_IDLE;
            ready = 1'b1;
          end else if (cmd == CMD_NONE || phase >= flen || phase >= FrameBytes) begin
            drop_link();
          end else begin
            r.read_byte = frame[phase];
            phase = phase + 4'd1;
            // end of frame: a config command settles config mode
            if (phase == flen) begin
              frames++;
              if (cmd == CMD_CONFIG) begin
                cfg = (param == 8'd1);
                if (cfg) begin
                  dshock = 1'b1;
                  stat_ok = 1'b1;
                  cfg_entries++;
                end
              end
              drop_link();
            end
          end
        end
        KIND_PRESS:   buttons = buttons & ~it.button_mask;
        KIND_RELEASE: buttons = buttons | it.button_mask;
        KIND_AXIS:    sticks[it.axis_select] = it.axis_value;
        KIND_MODE_BTN: begin
          if (!lock && !cfg) begin
            analog = !analog;
            quiet_rumble();
            if (dshock) stat_ok = 1'b0;
          end
        end
        default: ;
      endcase
      r.tx_ready    = ready;
      r.small_motor = motor[0];
      r.large_motor = motor[1];
      r.analog_mode = analog;
      return r;
    endfunction

    function void note_item(item_t it);
      items++;
      owed_replies.push_back(pad_reply(it));
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH reply %0d %s: got %0h, expected %0h", checked, what, got, want);
    endfunction

    // Compare one reply with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (owed_replies.size() == 0) begin
        report("unexpected reply, read_byte", got.read_byte, 0);
        return;
      end
      want = owed_replies.pop_front();
      if (got.read_byte != want.read_byte)
        report("read_byte", got.read_byte, want.read_byte);
      if (got.tx_ready != want.tx_ready)
        report("tx_ready", got.tx_ready, want.tx_ready);
      if (got.small_motor != want.small_motor)
        report("small_motor", got.small_motor, want.small_motor);
      if (got.large_motor != want.large_motor)
        report("large_motor", got.large_motor, want.large_motor);
      if (got.analog_mode != want.analog_mode)
        report("analog_mode", got.analog_mode, want.analog_mode);
      checked++;
    endfunction
  endclass

endpackage

@@ sim/gamepad_serial_responder_tb.sv @@
// Testbench for gamepad_serial_responder: drives host bytes and pad events,
// checks every reply against pad_scoreboard. Depends on gsr_pkg and pad_check_pkg.
`timescale 1ns / 1ps

module gamepad_serial_responder_tb;
  import gsr_pkg::*;
  import pad_check_pkg::*;

  localparam int ItemTarget = 900;
  localparam int QuietFrom  = 780;
  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  logic [2:0]  kind = KIND_READ;
  logic [7:0]  host_byte = 8'h00;
  logic [15:0] button_mask = 16'h0000;
  logic [1:0]  axis_select = 2'd0;
  logic [7:0]  axis_value = 8'h00;
  logic        in_stall, out_valid, tx_ready, analog_mode;
  logic [7:0]  read_byte, small_motor, large_motor;

  pad_scoreboard sb;
  bit            quiet = 1'b0;
  bit            calm = 1'b0;
  int unsigned   cycles = 0;

  gamepad_serial_responder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .host_byte   (host_byte),
    .button_mask (button_mask),
    .axis_select (axis_select),
    .axis_value  (axis_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .tx_ready    (tx_ready),
    .small_motor (small_motor),
    .large_motor (large_motor),
    .analog_mode (analog_mode)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Give up if the run hangs
  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("gamepad_serial_responder_tb: done, errors");
    $finish;
  end

  // Stall the reply side in short bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each reply transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({read_byte, tx_ready, small_motor, large_motor, analog_mode});
  end

  // Drive one item and hold it until the transfer
  task automatic send_item(input logic [2:0] k, input logic [7:0] hb,
                           input logic [15:0] bm, input logic [1:0] ax,
                           input logic [7:0] av);
    item_t it;
    if (!quiet && !calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    it = {k, hb, bm, ax, av};
    kind        <= k;
    host_byte   <= hb;
    button_mask <= bm;
    axis_select <= ax;
    axis_value  <= av;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_item(KIND_WRITE, b, 16'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic take_byte();
    send_item(KIND_READ, 8'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic pad_event(input logic [2:0] k, input logic [15:0] bm,
                           input logic [1:0] ax, input logic [7:0] av);
    send_item(k, 8'($urandom), bm, ax, av);
  endtask

  // Parameter bytes biased toward the values the commands decode
  function automatic logic [7:0] pick_param();
    case ($urandom_range(0, 7))
      0, 1:    return 8'($urandom_range(0, 1));
      2:       return 8'h03;
      3:       return 8'h41;
      4:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return STICK_LOW;
      2:       return STICK_LOW + 8'd1;
      3:       return STICK_HIGH - 8'd1;
      4:       return STICK_HIGH;
      5:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_event();
    case ($urandom_range(0, 9))
      0, 1, 2: pad_event(KIND_PRESS, 16'($urandom), 2'($urandom), 8'($urandom));
      3, 4:    pad_event(KIND_RELEASE, 16'($urandom), 2'($urandom), 8'($urandom));
      5, 6, 7: pad_event(KIND_AXIS, 16'($urandom), 2'($urandom), pick_axis());
      8:       pad_event(KIND_MODE_BTN, 16'($urandom), 2'($urandom), 8'($urandom));
      default: pad_event($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7,
                         16'($urandom), 2'($urandom), 8'($urandom));
    endcase
  endtask

  // One host exchange: wake the link, send a command, then swap bytes to the end
  task automatic run_exchange();
    logic [7:0] c;
    int         n;
    int         r;
    n = 0;
    while (sb.phase != PH_IDLE && n < 12) begin
      take_byte();
      n++;
    end
    r = $urandom_range(0, 19);
    if (r == 0)
      c = 8'($urandom);
    else if (sb.cfg && r < 18)
      c = {CMD_GROUP, 4'($urandom)};
    else
      c = r[0] ? CMD_POLL : CMD_CONFIG;
    put_byte(c);
    for (int p = 0; p < 10 && sb.phase != PH_HIZ; p++) begin
      if ($urandom_range(0, 15) == 0) random_event();
      if ($urandom_range(0, 29) == 0) break;
      take_byte();
      if (sb.phase == PH_HIZ) break;
      put_byte(pick_param());
    end
  endtask

  initial begin
    int r;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: wake-up, bad command, a digital poll with folded d-pad and
    // rumble, reads with no command, writes while high impedance, mode button
    take_byte();
    put_byte(CMD_NONE);
    take_byte();
    pad_event(KIND_PRESS, 16'hffff, 2'd0, 8'h00);
    pad_event(KIND_AXIS, 16'h0000, 2'd2, 8'd0);
    pad_event(KIND_AXIS, 16'hffff, 2'd3, 8'hff);
    put_byte(CMD_POLL);
    take_byte();
    take_byte();
    put_byte(8'h41);
    take_byte();
    put_byte(8'h01);
    take_byte();
    take_byte();
    take_byte();
    put_byte(CMD_POLL);
    pad_event(KIND_RELEASE, 16'hffff, 2'd1, 8'h00);
    pad_event(KIND_AXIS, 16'h0000, 2'd0, 8'hff);
    pad_event(KIND_MODE_BTN, 16'h0000, 2'd0, 8'h00);
    pad_event(KIND_MODE_BTN, 16'hffff, 2'd3, 8'hff);
    pad_event(KIND_SPARE_6, 16'h0000, 2'd0, 8'h00);
    send_item(KIND_SPARE_7, 8'hff, 16'hffff, 2'd3, 8'hff);
    pad_event(KIND_RELEASE, 16'h0000, 2'd2, 8'h80);

    // Random: mostly well-formed exchanges, some pad events and noise
    while (sb.items < ItemTarget) begin
      if (sb.items > QuietFrom) quiet = 1'b1;
      if ($urandom_range(0, 15) == 0) calm = !calm;
      r = $urandom_range(0, 9);
      if (r < 7)
        run_exchange();
      else if (r < 9)
        random_event();
      else
        send_item(3'($urandom), 8'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
    end
    in_valid <= 1'b0;

    // Drain the owed replies, then let the pipeline settle
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d pad items, %0d replies compared in %0d cycles.",
             sb.items, sb.checked, cycles);
    $display("Host frames completed: %0d, entries into config mode: %0d.",
             sb.frames, sb.cfg_entries);
    if (sb.errors == 0) begin
      $display("gamepad_serial_responder_tb: done, clean");
    end else begin
      $display("gamepad_serial_responder_tb: done, errors");
    end
    $finish;
  end

endmodule
